@@ hdl/vgu_pkg.sv @@
`default_nettype none
package vgu_pkg;

  localparam int unsigned OpW     = 32;
  localparam int unsigned ProdW   = 2 * OpW;
  localparam int unsigned ScalarW = 49;
  localparam int unsigned SqLat   = 32;

  typedef enum logic [2:0] {
    KIND_DOT   = 3'd0,
    KIND_SQLEN = 3'd1,
    KIND_LEN   = 3'd2,
    KIND_NORM  = 3'd3,
    KIND_CROSS = 3'd4
  } kind_e;

  typedef struct packed {
    logic [2:0]            kind;
    logic signed [OpW-1:0] a_x;
    logic signed [OpW-1:0] a_y;
    logic signed [OpW-1:0] a_z;
    logic signed [OpW-1:0] b_x;
    logic signed [OpW-1:0] b_y;
    logic signed [OpW-1:0] b_z;
  } vgu_in_t;

  typedef struct packed {
    logic signed [ScalarW-1:0] scalar_out;
    logic signed [OpW-1:0]     vec_x;
    logic signed [OpW-1:0]     vec_y;
    logic signed [OpW-1:0]     vec_z;
    logic                      zero_length;
    logic                      saturated;
  } vgu_out_t;

  // partial result carried past the square root and divider
  typedef struct packed {
    logic [2:0]                kind;
    logic signed [ScalarW-1:0] scalar;
    logic signed [OpW-1:0]     vx;
    logic signed [OpW-1:0]     vy;
    logic signed [OpW-1:0]     vz;
    logic                      sat;
    logic signed [OpW-1:0]     ax;
    logic signed [OpW-1:0]     ay;
    logic signed [OpW-1:0]     az;
  } vgu_side_t;

  localparam logic signed [ProdW+1:0] ScMax = (66'sd1 <<< (ScalarW - 1)) - 66'sd1;
  localparam logic signed [ProdW+1:0] ScMin = -(66'sd1 <<< (ScalarW - 1));
  localparam logic signed [ProdW:0]   CrMax = (65'sd1 <<< (OpW - 1)) - 65'sd1;
  localparam logic signed [ProdW:0]   CrMin = -(65'sd1 <<< (OpW - 1));

endpackage
`default_nettype wire

@@ hdl/vec3_geometry_unit.sv @@
// 3-vector unit in signed fixed point: dot, squared length, length,
// normalize and cross. One beat is accepted every cycle unless the output is
// stalled, and each gives one result beat. Every beat passes the 32-stage
// square root pipeline followed by the FRAC_BITS+1 stage divider; the whole
// pipeline holds while a finished result is stalled at the output.
`default_nettype none
module vec3_geometry_unit
  import vgu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire vgu_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output vgu_out_t      out_data_o
);

  localparam int unsigned DivLat = FRAC_BITS + 1;
  localparam int unsigned NV     = 3 + SqLat + DivLat + 1;

  logic [NV-1:0] v_q;
  logic          adv;

  assign adv        = !(v_q[NV-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NV-2:0], in_valid_i};
    end
  end

  // input register
  vgu_in_t s0_q, s1_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_q <= in_data_i;
      s1_q <= s0_q;
    end
  end

  // operand routing to the lanes
  logic signed [OpW-1:0]   la0 [3];
  logic signed [OpW-1:0]   lb0 [3];
  logic signed [OpW-1:0]   la1 [3];
  logic signed [OpW-1:0]   lb1 [3];
  logic signed [ProdW-1:0] p0  [3];
  logic signed [ProdW-1:0] p1  [3];

  always_comb begin
    if (s0_q.kind == KIND_CROSS) begin
      la0[0] = s0_q.a_y; lb0[0] = s0_q.b_z; la1[0] = s0_q.a_z; lb1[0] = s0_q.b_y;
      la0[1] = s0_q.a_z; lb0[1] = s0_q.b_x; la1[1] = s0_q.a_x; lb1[1] = s0_q.b_z;
      la0[2] = s0_q.a_x; lb0[2] = s0_q.b_y; la1[2] = s0_q.a_y; lb1[2] = s0_q.b_x;
    end else begin
      la0[0] = s0_q.a_x; la0[1] = s0_q.a_y; la0[2] = s0_q.a_z;
      if (s0_q.kind == KIND_DOT) begin
        lb0[0] = s0_q.b_x; lb0[1] = s0_q.b_y; lb0[2] = s0_q.b_z;
      end else begin
        lb0[0] = s0_q.a_x; lb0[1] = s0_q.a_y; lb0[2] = s0_q.a_z;
      end
      for (int k = 0; k < 3; k++) begin
        la1[k] = '0;
        lb1[k] = '0;
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    vgu_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .a0_i  (la0[k]),
      .b0_i  (lb0[k]),
      .a1_i  (la1[k]),
      .b1_i  (lb1[k]),
      .p0_o  (p0[k]),
      .p1_o  (p1[k])
    );
  end

  // merge: sums, rescale, clamp
  logic signed [ProdW+1:0] sum3, sum_sh;
  logic signed [ProdW:0]   dif  [3];
  logic signed [ProdW:0]   dsh  [3];
  logic signed [OpW-1:0]   cr   [3];
  logic                    cr_sat;
  vgu_side_t               sb_d, sb2_q;
  logic [ProdW-1:0]        sq2_q;

  always_comb begin
    sum3   = (ProdW+2)'(p0[0]) + (ProdW+2)'(p0[1]) + (ProdW+2)'(p0[2]);
    sum_sh = sum3 >>> FRAC_BITS;
    cr_sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      dif[k] = (ProdW+1)'(p0[k]) - (ProdW+1)'(p1[k]);
      dsh[k] = dif[k] >>> FRAC_BITS;
      if (dsh[k] > CrMax) begin
        cr[k]  = CrMax[OpW-1:0];
        cr_sat = 1'b1;
      end else if (dsh[k] < CrMin) begin
        cr[k]  = CrMin[OpW-1:0];
        cr_sat = 1'b1;
      end else begin
        cr[k]  = dsh[k][OpW-1:0];
      end
    end
    sb_d        = '0;
    sb_d.kind   = s1_q.kind;
    sb_d.ax     = s1_q.a_x;
    sb_d.ay     = s1_q.a_y;
    sb_d.az     = s1_q.a_z;
    if (sum_sh > ScMax) begin
      sb_d.scalar = ScMax[ScalarW-1:0];
    end else if (sum_sh < ScMin) begin
      sb_d.scalar = ScMin[ScalarW-1:0];
    end else begin
      sb_d.scalar = sum_sh[ScalarW-1:0];
    end
    sb_d.vx  = cr[0];
    sb_d.vy  = cr[1];
    sb_d.vz  = cr[2];
    sb_d.sat = cr_sat;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sb2_q <= sb_d;
      sq2_q <= sum3[ProdW-1:0];
    end
  end

  // square root with aligned sideband
  logic [OpW-1:0] root;
  vgu_side_t      sd_q [SqLat];

  vgu_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (sq2_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0] <= sb2_q;
      for (int i = 1; i < SqLat; i++) begin
        sd_q[i] <= sd_q[i-1];
      end
    end
  end

  // per-component divide for normalize
  vgu_side_t      sdl;
  logic [OpW-1:0] mag [3];
  logic [FRAC_BITS:0] qv [3];

  assign sdl    = sd_q[SqLat-1];
  assign mag[0] = sdl.ax[OpW-1] ? (~sdl.ax + 1'b1) : sdl.ax;
  assign mag[1] = sdl.ay[OpW-1] ? (~sdl.ay + 1'b1) : sdl.ay;
  assign mag[2] = sdl.az[OpW-1] ? (~sdl.az + 1'b1) : sdl.az;

  for (genvar k = 0; k < 3; k++) begin : g_div
    vgu_ndiv #(.FracBits(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (mag[k]),
      .den_i (root),
      .q_o   (qv[k])
    );
  end

  vgu_side_t      dd_q [DivLat];
  logic [OpW-1:0] dr_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dd_q[0] <= sdl;
      dr_q[0] <= root;
      for (int i = 1; i < DivLat; i++) begin
        dd_q[i] <= dd_q[i-1];
        dr_q[i] <= dr_q[i-1];
      end
    end
  end

  // final select
  vgu_side_t             fs;
  logic [OpW-1:0]        fr;
  logic signed [OpW-1:0] qe [3];
  vgu_out_t              out_d, out_q;

  assign fs = dd_q[DivLat-1];
  assign fr = dr_q[DivLat-1];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qe[k] = OpW'(qv[k]);
    end
    out_d = '0;
    case (fs.kind)
      KIND_DOT, KIND_SQLEN: begin
        out_d.scalar_out = fs.scalar;
      end
      KIND_LEN: begin
        out_d.scalar_out = ScalarW'(fr);
      end
      KIND_NORM: begin
        if (fr == '0) begin
          out_d.zero_length = 1'b1;
        end else begin
          out_d.vec_x = fs.ax[OpW-1] ? -qe[0] : qe[0];
          out_d.vec_y = fs.ay[OpW-1] ? -qe[1] : qe[1];
          out_d.vec_z = fs.az[OpW-1] ? -qe[2] : qe[2];
        end
      end
      KIND_CROSS: begin
        out_d.vec_x     = fs.vx;
        out_d.vec_y     = fs.vy;
        out_d.vec_z     = fs.vz;
        out_d.saturated = fs.sat;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = v_q[NV-1];
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_free_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  a_zero_vec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_length) |->
      (out_data_o.vec_x == '0 && out_data_o.vec_y == '0 && out_data_o.vec_z == '0
       && out_data_o.scalar_out == '0))
    else $error("zero length with nonzero result");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.zero_length && out_data_o.saturated))
    else $error("both flags set");
`endif

endmodule
`default_nettype wire

@@ hdl/vgu_lane.sv @@
`default_nettype none
module vgu_lane
  import vgu_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [OpW-1:0]   a0_i,
  input  wire logic signed [OpW-1:0]   b0_i,
  input  wire logic signed [OpW-1:0]   a1_i,
  input  wire logic signed [OpW-1:0]   b1_i,
  output logic signed [ProdW-1:0]      p0_o,
  output logic signed [ProdW-1:0]      p1_o
);

  logic signed [ProdW-1:0] p0_q, p1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p0_q <= ProdW'(a0_i) * ProdW'(b0_i);
      p1_q <= ProdW'(a1_i) * ProdW'(b1_i);
    end
  end

  assign p0_o = p0_q;
  assign p1_o = p1_q;

endmodule
`default_nettype wire

@@ hdl/vgu_isqrt.sv @@
`default_nettype none
module vgu_isqrt
  import vgu_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic [ProdW-1:0]   rad_i,
  output logic [OpW-1:0]          root_o
);

  logic [OpW+3:0]   rem_q  [SqLat-1];
  logic [ProdW-1:0] x_q    [SqLat-1];
  logic [OpW-1:0]   root_q [SqLat];

  for (genvar g = 0; g < SqLat; g++) begin : g_stage
    logic [OpW+3:0]   rin, sh, trial, rem_d;
    logic [OpW-1:0]   oin, root_d;
    logic [ProdW-1:0] xin;
    logic             ge;

    if (g == 0) begin : g_first
      assign rin = '0;
      assign oin = '0;
      assign xin = rad_i;
    end else begin : g_next
      assign rin = rem_q[g-1];
      assign oin = root_q[g-1];
      assign xin = x_q[g-1];
    end

    always_comb begin
      sh     = {rin[OpW+1:0], xin[ProdW-1:ProdW-2]};
      trial  = {2'b00, oin, 2'b01};
      ge     = (sh >= trial);
      rem_d  = ge ? (sh - trial) : sh;
      root_d = {oin[OpW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[g] <= root_d;
      end
    end

    if (g < SqLat - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= rem_d;
          x_q[g]   <= {xin[ProdW-3:0], 2'b00};
        end
      end
    end
  end

  assign root_o = root_q[SqLat-1];

endmodule
`default_nettype wire

@@ hdl/vgu_ndiv.sv @@
`default_nettype none
module vgu_ndiv
  import vgu_pkg::*;
#(
  parameter int unsigned FracBits = 16
) (
  input  wire logic              clk_i,
  input  wire logic              en_i,
  input  wire logic [OpW-1:0]    num_i,
  input  wire logic [OpW-1:0]    den_i,
  output logic [FracBits:0]      q_o
);

  localparam int unsigned NSt = FracBits + 1;

  logic [OpW-1:0]    rem_q [NSt-1];
  logic [OpW-1:0]    den_q [NSt-1];
  logic [FracBits:0] q_q   [NSt];

  // quotient is at most 2^FracBits since |num| <= den
  for (genvar g = 0; g < NSt; g++) begin : g_stage
    logic [OpW-1:0]    rin, din, rem_d;
    logic [FracBits:0] qin;
    logic              bin, ge;
    logic [OpW:0]      sh, diff;

    if (g == 0) begin : g_first
      assign rin = {1'b0, num_i[OpW-1:1]};
      assign din = den_i;
      assign qin = '0;
      assign bin = num_i[0];
    end else begin : g_next
      assign rin = rem_q[g-1];
      assign din = den_q[g-1];
      assign qin = q_q[g-1];
      assign bin = 1'b0;
    end

    always_comb begin
      sh    = {rin, bin};
      diff  = sh - {1'b0, din};
      ge    = (sh >= {1'b0, din});
      rem_d = ge ? diff[OpW-1:0] : sh[OpW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[g] <= {qin[FracBits-1:0], ge};
      end
    end

    if (g < NSt - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[g] <= rem_d;
          den_q[g] <= din;
        end
      end
    end
  end

  assign q_o = q_q[NSt-1];

endmodule
`default_nettype wire

@@ dv/vec3_geometry_unit_tb.sv @@
`default_nettype none
module vec3_geometry_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vgu_pkg::*;

  localparam int unsigned FracBits = 16;
  localparam int unsigned Latency = FracBits + 37;
  localparam int unsigned NumRandom = 880;
  localparam longint unsigned CycleLimit = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  vgu_in_t in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  vgu_out_t out_data_o;

  vec3_geometry_unit #(.FRAC_BITS(FracBits)) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  typedef struct {
    vgu_in_t  beat;
    logic     known;
    vgu_out_t result;
  } stim_row_t;

  vgu_out_t  pending_results[$];
  stim_row_t stim_rows[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned zero_flags;
  int unsigned sat_flags;
  longint unsigned cycles;
  logic quiet_tail;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic signed [65:0] floor_rescale(logic signed [65:0] p);
    return p >>> FracBits;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] unit_comp(logic signed [31:0] c, logic [63:0] len);
    logic [95:0] mag;
    logic [95:0] q;
    mag = (c < 0) ? 96'(-64'(c)) : 96'(c);
    q = (mag << FracBits) / 96'(len);
    return (c < 0) ? -32'(q) : 32'(q);
  endfunction

  function automatic logic signed [31:0] clamp_cross(logic signed [65:0] p, logic signed [65:0] q,
                                                     inout logic sat);
    logic signed [65:0] v;
    v = floor_rescale(p - q);
    if (v > 66'sd2147483647) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -66'sd2147483648) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [48:0] clamp_scalar(logic signed [65:0] v);
    if (v > ScMax) return ScMax[48:0];
    if (v < ScMin) return ScMin[48:0];
    return v[48:0];
  endfunction

  function automatic vgu_out_t vec3_predict(vgu_in_t b);
    vgu_out_t r;
    logic signed [65:0] ax, ay, az, bx, by, bz;
    logic [63:0] sum_sq;
    logic [63:0] len;
    logic sat;
    r = '0;
    sat = 1'b0;
    ax = 66'(b.a_x);
    ay = 66'(b.a_y);
    az = 66'(b.a_z);
    bx = 66'(b.b_x);
    by = 66'(b.b_y);
    bz = 66'(b.b_z);
    sum_sq = 64'(ax * ax) + 64'(ay * ay) + 64'(az * az);
    len = int_sqrt(sum_sq);
    case (b.kind)
      KIND_DOT: r.scalar_out = clamp_scalar(floor_rescale(ax * bx + ay * by + az * bz));
      KIND_SQLEN: r.scalar_out = clamp_scalar(floor_rescale(ax * ax + ay * ay + az * az));
      KIND_LEN: r.scalar_out = 49'(len);
      KIND_NORM: begin
        if (len == 0) begin
          r.zero_length = 1'b1;
        end else begin
          r.vec_x = unit_comp(b.a_x, len);
          r.vec_y = unit_comp(b.a_y, len);
          r.vec_z = unit_comp(b.a_z, len);
        end
      end
      KIND_CROSS: begin
        r.vec_x = clamp_cross(ay * bz, az * by, sat);
        r.vec_y = clamp_cross(az * bx, ax * bz, sat);
        r.vec_z = clamp_cross(ax * by, ay * bx, sat);
        r.saturated = sat;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 8)) - 32'd4;
      1: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 3)
                                     : 32'h80000000 + $urandom_range(0, 3);
      2: return 32'($signed(16'($urandom)));
      3: return 32'($signed(24'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  function automatic vgu_in_t rand_beat();
    vgu_in_t b;
    b.kind = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    b.a_x = rand_comp();
    b.a_y = rand_comp();
    b.a_z = rand_comp();
    b.b_x = rand_comp();
    b.b_y = rand_comp();
    b.b_z = rand_comp();
    if ($urandom_range(0, 9) == 0) begin
      b.a_x = '0;
      b.a_y = '0;
      b.a_z = '0;
    end
    return b;
  endfunction

  function automatic vgu_in_t mk(logic [2:0] k, logic [31:0] ax, logic [31:0] ay,
                                 logic [31:0] az, logic [31:0] bx, logic [31:0] by,
                                 logic [31:0] bz);
    vgu_in_t b;
    b.kind = k;
    b.a_x = ax;
    b.a_y = ay;
    b.a_z = az;
    b.b_x = bx;
    b.b_y = by;
    b.b_z = bz;
    return b;
  endfunction

  function automatic vgu_out_t res(logic [48:0] s, logic [31:0] x, logic [31:0] y,
                                   logic [31:0] z, logic zl, logic st);
    vgu_out_t r;
    r.scalar_out = s;
    r.vec_x = x;
    r.vec_y = y;
    r.vec_z = z;
    r.zero_length = zl;
    r.saturated = st;
    return r;
  endfunction

  task automatic add_row(vgu_in_t b, logic known, vgu_out_t r);
    stim_row_t row;
    row.beat = b;
    row.known = known;
    row.result = r;
    stim_rows.push_back(row);
  endtask

  task automatic build_table();
    localparam logic [31:0] One = 32'h0001_0000;
    localparam logic [31:0] Mx = 32'h7fffffff;
    localparam logic [31:0] Mn = 32'h80000000;
    add_row(mk(KIND_NORM, 0, 0, 0, 5, 6, 7), 1, res(0, 0, 0, 0, 1, 0));
    add_row(mk(KIND_DOT, One, One, One, One, 2 * One, 3 * One), 1,
            res(49'(6 * One), 0, 0, 0, 0, 0));
    add_row(mk(KIND_LEN, 3 * One, 4 * One, 0, 0, 0, 0), 1, res(49'(5 * One), 0, 0, 0, 0, 0));
    add_row(mk(KIND_NORM, 3 * One, 0, 0, 0, 0, 0), 1, res(0, One, 0, 0, 0, 0));
    add_row(mk(KIND_NORM, 0, -(2 * One), 0, 0, 0, 0), 1, res(0, 0, -One, 0, 0, 0));
    add_row(mk(KIND_CROSS, One, 0, 0, 0, One, 0), 1, res(0, 0, 0, One, 0, 0));
    add_row(mk(KIND_CROSS, Mn, Mn, Mn, Mx, Mn, Mx), 0, '0);
    add_row(mk(KIND_CROSS, Mx, Mn, Mx, Mn, Mx, Mn), 0, '0);
    add_row(mk(KIND_DOT, Mn, Mn, Mn, Mn, Mn, Mn), 0, '0);
    add_row(mk(KIND_DOT, Mx, Mx, Mx, Mn, Mn, Mn), 0, '0);
    add_row(mk(KIND_SQLEN, Mn, Mn, Mn, 0, 0, 0), 0, '0);
    add_row(mk(KIND_SQLEN, -1, 1, -1, 0, 0, 0), 0, '0);
    add_row(mk(KIND_LEN, Mn, Mn, Mn, 0, 0, 0), 0, '0);
    add_row(mk(KIND_LEN, Mx, Mx, Mx, 0, 0, 0), 0, '0);
    add_row(mk(KIND_NORM, Mn, Mx, 1, 0, 0, 0), 0, '0);
    add_row(mk(KIND_NORM, 1, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(KIND_NORM, -1, -1, -1, 0, 0, 0), 0, '0);
    add_row(mk(KIND_DOT, -1, -1, -1, 1, 1, 1), 0, '0);
    add_row(mk(KIND_CROSS, -1, 3, 7, 5, -2, 9), 0, '0);
    add_row(mk(3'd5, Mx, Mn, 1, 2, 3, 4), 1, '0);
    add_row(mk(3'd6, -1, -1, -1, -1, -1, -1), 1, '0);
    add_row(mk(3'd7, Mn, Mn, Mn, Mx, Mx, Mx), 1, '0);
    add_row(mk(3'd7, -1, -1, -1, -1, -1, -1), 1, '0);
  endtask

  // sender: holds the beat until accepted, idles in random bursts
  task automatic send_beat(vgu_in_t b);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // the expected result is queued from the monitor side on acceptance
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      pending_results.push_back(vec3_predict(in_data_i));
    end
  end

  always @(posedge clk_i) begin
    vgu_out_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", out_data_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (exp_r.zero_length) zero_flags++;
        if (exp_r.saturated) sat_flags++;
        if (out_data_o !== exp_r) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected %p", exp_r);
            $display("           actual %p", out_data_o);
          end
        end
      end
    end
  end

  // receiver stall in random bursts
  initial begin
    int unsigned burst;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(5, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("vec3_geometry_unit verification failed");
        $finish;
      end
    end
  end

  // directed rows with a typed-in result are also checked against the predictor
  initial begin
    vgu_out_t calc;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rst_ni = 1'b0;
    mismatches = 0;
    results_seen = 0;
    zero_flags = 0;
    sat_flags = 0;
    quiet_tail = 1'b0;
    build_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (stim_rows[i]) begin
      if (stim_rows[i].known) begin
        calc = vec3_predict(stim_rows[i].beat);
        if (calc !== stim_rows[i].result) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row %0d: expected %p, model %p", i, stim_rows[i].result, calc);
        end
      end
      send_beat(stim_rows[i].beat);
    end
    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom - 120) quiet_tail = 1'b1;
      send_beat(rand_beat());
    end
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
    $display("covered %0d results over all kinds incl. extremes and unused codes;",
             results_seen);
    $display("%0d zero-vector normalizes, %0d saturated crosses", zero_flags, sat_flags);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("vec3_geometry_unit verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("vec3_geometry_unit verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
